@@ rtl/tmwf_pkg.sv @@
package tmwf_pkg;

    localparam int WINDOW_LENGTH = 12;
    localparam int HIST_DEPTH    = WINDOW_LENGTH - 1;
    localparam int KEPT_COUNT    = WINDOW_LENGTH - 2;
    localparam int DATA_W        = 24;
    // The window sum of WINDOW_LENGTH samples fits in this many bits.
    localparam int SUM_W         = DATA_W + $clog2(WINDOW_LENGTH);
    // The step counter only has to count the history walk.
    localparam int CNT_W         = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    // Division by KEPT_COUNT is a multiply by a rounded-up fixed-point
    // reciprocal. With this shift the rounding error stays below one unit of
    // the quotient for every sum that fits in SUM_W bits.
    localparam int RECIP_SHIFT   = SUM_W + $clog2(KEPT_COUNT);
    localparam int RECIP_W       = SUM_W + 1;
    localparam int PROD_W        = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(KEPT_COUNT) - 64'd1) / 64'(KEPT_COUNT));

    typedef logic [DATA_W-1:0] data_t;

    typedef struct packed {
        logic load;
        logic walk;
        logic trim_hi;
        logic trim_lo;
        logic divide;
        logic finish;
    } tmwf_ctrl_t;

endpackage

@@ rtl/tmwf_history.sv @@
module tmwf_history
    import tmwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tmwf_ctrl_t ctrl,
    input  data_t      fresh,
    output data_t      tap
);

    // Entry zero is the newest sample. A rotation moves every entry one place
    // toward entry zero, so a full lap of HIST_DEPTH rotations restores the order.
    data_t hist_reg [HIST_DEPTH];

    assign tap = hist_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctrl.walk)
        begin
            for (int i = 0; i < HIST_DEPTH - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[HIST_DEPTH-1] <= hist_reg[0];
        end
        else if (ctrl.trim_hi)
        begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            hist_reg[0] <= fresh;
        end
    end

endmodule

@@ rtl/tmwf_datapath.sv @@
module tmwf_datapath
    import tmwf_pkg::*;
(
    input  logic       clk,
    input  tmwf_ctrl_t ctrl,
    input  data_t      sample,
    input  data_t      hist_tap,
    output data_t      fresh,
    output data_t      quotient
);

    data_t              fresh_reg;
    logic [SUM_W-1:0]   acc_reg;
    data_t              hi_reg;
    data_t              lo_reg;
    data_t              dv_reg;

    logic [SUM_W-1:0]   alu_a;
    logic [SUM_W-1:0]   alu_b;
    logic               alu_sub;
    logic [SUM_W-1:0]   alu_res;
    logic [PROD_W-1:0]  prod;

    assign fresh    = fresh_reg;
    assign quotient = dv_reg;

    // Shared add/subtract unit: window sum and trimming.
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        if (ctrl.walk)
        begin
            alu_b = SUM_W'(hist_tap);
        end
        else if (ctrl.trim_hi)
        begin
            alu_b   = SUM_W'(hi_reg);
            alu_sub = 1'b1;
        end
        else if (ctrl.trim_lo)
        begin
            alu_b   = SUM_W'(lo_reg);
            alu_sub = 1'b1;
        end
    end

    // The window sum never exceeds SUM_W bits, so no carry is kept.
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // The trimmed sum times the reciprocal, shifted down, is the quotient.
    assign prod = PROD_W'(acc_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            fresh_reg <= sample;
            acc_reg   <= SUM_W'(sample);
            hi_reg    <= sample;
            lo_reg    <= sample;
        end
        else if (ctrl.walk)
        begin
            acc_reg <= alu_res;
            if (hist_tap > hi_reg)
            begin
                hi_reg <= hist_tap;
            end
            if (hist_tap < lo_reg)
            begin
                lo_reg <= hist_tap;
            end
        end
        else if (ctrl.trim_hi || ctrl.trim_lo)
        begin
            acc_reg <= alu_res;
        end
        else if (ctrl.divide)
        begin
            dv_reg <= prod[RECIP_SHIFT +: DATA_W];
        end
    end

endmodule

@@ rtl/tmwf_ctrl.sv @@
module tmwf_ctrl
    import tmwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    input  logic       out_free,
    output logic       sample_ready,
    output tmwf_ctrl_t ctrl
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_WALK    = 6'b000010,
        ST_TRIM_HI = 6'b000100,
        ST_TRIM_LO = 6'b001000,
        ST_DIVIDE  = 6'b010000,
        ST_DONE    = 6'b100000
    } tmwf_state_t;

    tmwf_state_t      st_reg;
    tmwf_state_t      st_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign sample_ready = (st_reg == ST_IDLE);

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        ctrl     = '0;
        case (st_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    ctrl.load = 1'b1;
                    cnt_next  = '0;
                    st_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                ctrl.walk = 1'b1;
                if (cnt_reg == CNT_W'(HIST_DEPTH - 1))
                begin
                    cnt_next = '0;
                    st_next  = ST_TRIM_HI;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_TRIM_HI:
            begin
                ctrl.trim_hi = 1'b1;
                st_next      = ST_TRIM_LO;
            end
            ST_TRIM_LO:
            begin
                ctrl.trim_lo = 1'b1;
                cnt_next     = '0;
                st_next      = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                ctrl.divide = 1'b1;
                st_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctrl.finish = 1'b1;
                    st_next     = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/trimmed_mean_window_filter_unit.sv @@
// Sliding-window trimmed mean filter for 24-bit load-cell samples. Each request on the
// sample channel yields exactly one request on the filtered channel: the mean of the new
// sample and the eleven samples before it, after one largest and one smallest value are
// dropped, truncated toward zero. The history is all zeros after reset, so the first
// eleven results count those zeros as samples. One item is handled at a time by a single
// shared adder/subtractor under a small sequencer: it accepts the sample, walks the history
// ring (sum, maximum and minimum), subtracts the maximum and then the minimum, divides by
// ten as a multiply by a fixed-point reciprocal, and hands the result to the output
// register. A new sample is not taken before the previous one is through these steps;
// the output register lets the next sample be accepted while the previous result still
// waits, and the block stalls in its last step only if that earlier result has not yet
// been taken.
module trimmed_mean_window_filter_unit
    import tmwf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  sample_valid,
    output logic  sample_ready,
    input  data_t sample,
    output logic  filtered_valid,
    input  logic  filtered_ready,
    output data_t filtered
);

    tmwf_ctrl_t ctrl;
    data_t      hist_tap;
    data_t      fresh;
    data_t      quotient;
    logic       out_free;

    data_t      filtered_reg;
    logic       filtered_valid_reg;

    // The sequencer may hand over a new result once the held one is gone
    // or is being taken in this very cycle.
    assign out_free       = !filtered_valid_reg || filtered_ready;
    assign filtered       = filtered_reg;
    assign filtered_valid = filtered_valid_reg;

    tmwf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .out_free     (out_free),
        .sample_ready (sample_ready),
        .ctrl         (ctrl)
    );

    tmwf_history u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .fresh (fresh),
        .tap   (hist_tap)
    );

    tmwf_datapath u_datapath (
        .clk      (clk),
        .ctrl     (ctrl),
        .sample   (sample),
        .hist_tap (hist_tap),
        .fresh    (fresh),
        .quotient (quotient)
    );

    // Output register: holds one finished result until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filtered_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            filtered_valid_reg <= 1'b1;
        end
        else if (filtered_ready)
        begin
            filtered_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            filtered_reg <= quotient;
        end
    end

    // A finished result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> (!filtered_valid_reg || filtered_ready))
        else $error("result handed over while previous result still pending");

    // Once a sample is accepted the block is busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("block ready again right after accepting a sample");

    // A result appears only after the sequencer has finished an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(filtered_valid_reg) |-> $past(ctrl.finish))
        else $error("result valid without a finished item");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

// Testbench for the trimmed mean window filter. Every request that the block
// accepts on the sample channel is run through a local copy of the window
// filter. Each expected mean is then queued until the matching request
// arrives on the filtered channel, where the two are compared in order.
module tb;
    import tmwf_pkg::*;

    localparam int   RANDOM_ITEMS = 2000;
    localparam int   CYCLE_LIMIT  = 1_000_000;
    localparam int   TAIL_CYCLES  = 60;
    localparam int   REPORT_LIMIT = 10;
    localparam int   HOLD_AT      = 300;
    localparam int   HOLD_CYCLES  = 500;
    localparam int   PAUSE_AT     = 1200;
    localparam int   CALM_FIRST   = 600;
    localparam int   CALM_LAST    = 1000;
    localparam logic [DATA_W-1:0] FULL_SCALE = '1;

    // These are the ways the random part picks a new converter reading.
    typedef enum int {
        PICK_UNIFORM,
        PICK_NOISY,
        PICK_EXTREME,
        PICK_REPEAT,
        PICK_SPIKE
    } pick_t;

    // One row of the directed table. The expected mean is typed in only
    // where it is obvious, and every other row is checked against the
    // local filter.
    typedef struct {
        data_t smp;
        bit    known;
        data_t want;
    } stim_row_t;

    logic  clk;
    logic  rst_n;
    logic  sample_valid;
    logic  sample_ready;
    data_t sample;
    logic  filtered_valid;
    logic  filtered_ready;
    data_t filtered;

    // This is the local copy of the sample history, newest entry first.
    data_t     window_hist [HIST_DEPTH];
    // These are the expected means, oldest first.
    data_t     pending_means [$];
    stim_row_t directed_rows [$];

    int    errors       = 0;
    int    samples_sent = 0;
    int    means_seen   = 0;
    int    cycles       = 0;
    bit    sender_calm  = 1'b0;
    data_t base_level   = 24'h800000;
    data_t last_sample  = '0;

    trimmed_mean_window_filter_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample         (sample),
        .filtered_valid (filtered_valid),
        .filtered_ready (filtered_ready),
        .filtered       (filtered)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // A run that stops making progress is ended here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d means still pending.",
                     cycles, pending_means.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // This computes the mean of the new sample and the stored history after
    // one largest and one smallest value are dropped, and then shifts the
    // new sample into the history.
    function automatic data_t trimmed_mean(input data_t fresh);
        data_t            hi;
        data_t            lo;
        logic [SUM_W-1:0] total;
        hi    = fresh;
        lo    = fresh;
        total = SUM_W'(fresh);
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            if (window_hist[k] > hi)
                hi = window_hist[k];
            if (window_hist[k] < lo)
                lo = window_hist[k];
            total = total + SUM_W'(window_hist[k]);
        end
        total = total - SUM_W'(hi) - SUM_W'(lo);
        total = total / SUM_W'(KEPT_COUNT);
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            window_hist[k] = window_hist[k - 1];
        window_hist[0] = fresh;
        return data_t'(total);
    endfunction

    // The random readings are uniform over the full range or follow a level,
    // which jumps now and then, with a little noise, as a loaded scale would.
    // Spikes, rail values and repeated readings are mixed in so that the
    // trimming and the tie handling are exercised often.
    function automatic data_t next_reading();
        pick_t how;
        int    v;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            how = PICK_UNIFORM;
        else if (roll < 70)
            how = PICK_NOISY;
        else if (roll < 80)
            how = PICK_EXTREME;
        else if (roll < 90)
            how = PICK_REPEAT;
        else
            how = PICK_SPIKE;
        if ($urandom_range(0, 99) < 3)
            base_level = data_t'($urandom);
        case (how)
            PICK_UNIFORM: v = int'($urandom & 32'h00FF_FFFF);
            PICK_NOISY:   v = int'(base_level) + int'($urandom_range(0, 2000)) - 1000;
            PICK_EXTREME: v = $urandom_range(0, 1) ? int'(FULL_SCALE) : 0;
            PICK_REPEAT:  v = int'(last_sample);
            default:      v = int'(base_level) + int'($urandom_range(0, 200000)) - 100000;
        endcase
        if (v < 0)
            v = 0;
        if (v > int'(FULL_SCALE))
            v = int'(FULL_SCALE);
        last_sample = data_t'(v);
        return data_t'(v);
    endfunction

    // This offers one sample request and waits for the block to take it.
    // A random gap may come first, outside the calm stretch. Once the request
    // is accepted, its expected mean is queued, taken from the table where
    // one was typed in there.
    task automatic send_sample(input data_t s, input bit known, input data_t want);
        data_t mean;
        if (!sender_calm && $urandom_range(0, 99) < 10)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        mean = trimmed_mean(s);
        if (known)
            mean = want;
        pending_means.push_back(mean);
        samples_sent++;
    endtask

    task automatic add_row(input data_t s, input bit known, input data_t want);
        stim_row_t r;
        r.smp   = s;
        r.known = known;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    // The receiver checks every filtered request against the oldest expected
    // mean. It then chooses ready for the next cycle: a single long hold-off
    // that fills the block up, random stalls, and a calm stretch with no
    // stalls at all.
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        bit  calm;
        data_t want;
        hold_left      = 0;
        hold_done      = 1'b0;
        filtered_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && filtered_valid && filtered_ready)
            begin
                means_seen++;
                if (pending_means.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("Unexpected filtered result %h with nothing pending",
                                 filtered);
                end
                else
                begin
                    want = pending_means.pop_front();
                    if (filtered !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("Mean %0d mismatch: expected %h, got %h",
                                     means_seen, want, filtered);
                    end
                end
            end
            calm = (means_seen >= CALM_FIRST) && (means_seen < CALM_LAST);
            if (hold_left > 0)
            begin
                hold_left--;
                filtered_ready <= 1'b0;
            end
            else if (!hold_done && means_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                filtered_ready <= 1'b0;
            end
            else
                filtered_ready <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    initial
    begin : stimulus
        int n;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        for (int k = 0; k < HIST_DEPTH; k++)
            window_hist[k] = '0;

        // The directed part starts from a cleared history. A zero sample
        // gives zero. A single full-scale sample among zeros is trimmed
        // away. Once the window holds only full-scale values the mean is
        // full scale, and a lone zero among them is trimmed away again.
        // Alternating bit patterns and repeated values follow.
        add_row(24'h000000, 1'b1, 24'h000000);
        add_row(FULL_SCALE, 1'b1, 24'h000000);
        for (int k = 0; k < 10; k++)
            add_row(FULL_SCALE, 1'b0, '0);
        add_row(FULL_SCALE, 1'b1, FULL_SCALE);
        add_row(24'h000000, 1'b1, FULL_SCALE);
        add_row(24'hAAAAAA, 1'b0, '0);
        add_row(24'h555555, 1'b0, '0);
        add_row(24'h000001, 1'b0, '0);
        add_row(24'h800000, 1'b0, '0);
        add_row(24'h7FFFFF, 1'b0, '0);
        add_row(24'h123456, 1'b0, '0);
        add_row(24'h123456, 1'b0, '0);
        add_row(24'h123456, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].want);

        // In the random part the sender pauses once until the block has
        // drained completely, and it runs without gaps through one
        // stretch of the run.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_calm = (n >= CALM_FIRST) && (n < CALM_LAST);
            if (n == PAUSE_AT)
            begin
                sample_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_means.size() != 0);
            end
            send_sample(next_reading(), 1'b0, '0);
        end
        sample_valid <= 1'b0;

        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d samples (%0d from the directed table), checked %0d means.",
                 samples_sent, directed_rows.size(), means_seen);
        $display("The run covered rail values, ties, start-up zeros, output stalls ",
                 "and a full drain.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
        begin
            $display("%0d mismatches in total.", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
